// ===== design/gtpc_pkg.sv =====
// ---------------------------------------------------------------------------
// gtpc_pkg
// Shared types, constants and helpers of the graphic/text pixel compositor.
// ---------------------------------------------------------------------------
package gtpc_pkg;

    localparam int GPAL_DEPTH = 256;
    localparam int TPAL_DEPTH = 16;
    localparam int GPAL_AW    = $clog2(GPAL_DEPTH);
    localparam int TPAL_AW    = $clog2(TPAL_DEPTH);
    localparam int PAGE_SIDE  = 512;
    localparam int PAGE_CNT   = 4;

    typedef enum logic [1:0] {
        OP_PIXEL   = 2'd0,
        OP_WR_GPAL = 2'd1,
        OP_WR_TPAL = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CFG_COLOR_MODE   = 3'd0,
        CFG_LARGE_SCREEN = 3'd1,
        CFG_PAGE_ENABLE  = 3'd2,
        CFG_PAGE_PRIO    = 3'd3,
        CFG_GRAPHIC_EN   = 3'd4,
        CFG_TEXT_EN      = 3'd5,
        CFG_GLAYER_PRIO  = 3'd6,
        CFG_TLAYER_PRIO  = 3'd7
    } cfg_idx_t;

    localparam logic [1:0] MODE_16  = 2'd0;
    localparam logic [1:0] MODE_256 = 2'd1;

    typedef struct packed {
        logic [1:0] color_mode;
        logic       large_screen;
        logic [3:0] page_enable_mask;
        logic [7:0] page_priorities;
        logic       graphic_enable;
        logic       text_enable;
        logic [1:0] glayer_prio;
        logic [1:0] tlayer_prio;
    } cfg_t;

    // decoded request, ahead of the palette lookup
    typedef struct packed {
        op_t                op;
        logic [GPAL_AW-1:0] pal_index;
        logic [15:0]        data;
        logic               gshow;
        logic               gdirect;
        logic [GPAL_AW-1:0] gidx;
        logic               tshow;
        logic [TPAL_AW-1:0] tidx;
    } dec_t;

    // request after the palette lookup
    typedef struct packed {
        op_t         op;
        logic        gshow;
        logic        gdirect;
        logic [15:0] data;
        logic        tshow;
    } pal_t;

    function automatic logic [15:0] grbi_to_565(input logic [15:0] v);
        grbi_to_565 = {v[10:6], v[15:11], v[0], v[5:1]};
    endfunction

endpackage

// ===== design/graphic_text_pixel_compositor.sv =====
// ---------------------------------------------------------------------------
// graphic_text_pixel_compositor
// Per-pixel graphic/text layer compositor with palette load requests.
// ---------------------------------------------------------------------------
// Pipeline: a request passes through the decode, palette read and compose/output
// registers in that order before its result is offered on the output stream.
// Throughput: one request per cycle, set by each stage taking a new request
// whenever its output is free; the palettes take one read and one write a cycle.
// Reset: all configuration registers clear to zero, pipeline empties;
// palette contents are undefined until loaded.
module graphic_text_pixel_compositor
    import gtpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // x[9:0], y[19:10], gvram_word[35:20], text_bits[39:36],
    // palette_index[47:40], palette_value[63:48]
    input  logic [63:0] s_tdata,
    // op[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // color[15:0]
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t        cfg_reg;
    logic        d_valid;
    logic        d_ready;
    dec_t        d_dec;
    logic        p_valid;
    logic        p_ready;
    pal_t        p_pal;
    logic [15:0] p_gcolor;
    logic [15:0] p_tcolor;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_COLOR_MODE:   cfg_reg.color_mode       <= cfg_data[1:0];
                CFG_LARGE_SCREEN: cfg_reg.large_screen     <= cfg_data[0];
                CFG_PAGE_ENABLE:  cfg_reg.page_enable_mask <= cfg_data[3:0];
                CFG_PAGE_PRIO:    cfg_reg.page_priorities  <= cfg_data;
                CFG_GRAPHIC_EN:   cfg_reg.graphic_enable   <= cfg_data[0];
                CFG_TEXT_EN:      cfg_reg.text_enable      <= cfg_data[0];
                CFG_GLAYER_PRIO:  cfg_reg.glayer_prio      <= cfg_data[1:0];
                CFG_TLAYER_PRIO:  cfg_reg.tlayer_prio      <= cfg_data[1:0];
                default:          cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    gtpc_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (op_t'(s_tuser)),
        .in_x      (s_tdata[9:0]),
        .in_y      (s_tdata[19:10]),
        .in_word   (s_tdata[35:20]),
        .in_tbits  (s_tdata[39:36]),
        .in_pidx   (s_tdata[47:40]),
        .in_pval   (s_tdata[63:48]),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_dec   (d_dec)
    );

    gtpc_palette u_palette (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .in_dec    (d_dec),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .out_pal   (p_pal),
        .gcolor    (p_gcolor),
        .tcolor    (p_tcolor)
    );

    gtpc_compose u_compose (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (p_valid),
        .in_ready  (p_ready),
        .in_pal    (p_pal),
        .gcolor    (p_gcolor),
        .tcolor    (p_tcolor),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_color (m_tdata)
    );

    a_block_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready && d_valid && p_valid)
        else $error("input held off with room in the pipeline");

endmodule

// ===== design/gtpc_decode.sv =====
// ---------------------------------------------------------------------------
// gtpc_decode
// Select the front graphic index by page priority and decode the text index.
// ---------------------------------------------------------------------------
module gtpc_decode
    import gtpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  op_t         in_op,
    input  logic [9:0]  in_x,
    input  logic [9:0]  in_y,
    input  logic [15:0] in_word,
    input  logic [3:0]  in_tbits,
    input  logic [7:0]  in_pidx,
    input  logic [15:0] in_pval,
    output logic        out_valid,
    input  logic        out_ready,
    output dec_t        out_dec
);

    logic               valid_reg;
    dec_t               dec_reg;
    dec_t               dec_next;
    logic [7:0]         page_idx  [PAGE_CNT];
    logic               page_cand [PAGE_CNT];
    logic [3:0]         page_key  [PAGE_CNT];
    logic               pair_cand [2];
    logic [3:0]         pair_key  [2];
    logic [7:0]         pair_idx  [2];
    logic               found;
    logic [7:0]         found_idx;
    logic [1:0]         quad;
    logic [3:0]         quad_idx;
    logic               is16;
    logic               direct;
    logic               outside;
    logic               gshow_raw;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_dec   = dec_reg;

    assign is16    = (cfg.color_mode == MODE_16);
    assign direct  = cfg.color_mode[1];
    assign outside = in_x[9] || in_y[9];
    assign quad    = {in_y[9], in_x[9]};
    assign quad_idx = in_word[4*quad +: 4];

    always_comb
    begin
        for (int p = 0; p < PAGE_CNT; p++)
        begin
            page_idx[p]  = is16 ? {4'd0, in_word[4*p +: 4]} : in_word[8*(p%2) +: 8];
            page_cand[p] = cfg.page_enable_mask[p] && (page_idx[p] != 8'd0);
            page_key[p]  = {cfg.page_priorities[2*p +: 2], 2'(p)};
        end
        for (int k = 0; k < 2; k++)
        begin
            if (page_cand[2*k] && (!page_cand[2*k+1] || page_key[2*k] < page_key[2*k+1]))
            begin
                pair_cand[k] = 1'b1;
                pair_key[k]  = page_key[2*k];
                pair_idx[k]  = page_idx[2*k];
            end
            else
            begin
                pair_cand[k] = page_cand[2*k+1];
                pair_key[k]  = page_key[2*k+1];
                pair_idx[k]  = page_idx[2*k+1];
            end
        end
        found = pair_cand[0] || pair_cand[1];
        if (pair_cand[0] && (!pair_cand[1] || pair_key[0] < pair_key[1]))
            found_idx = pair_idx[0];
        else
            found_idx = pair_idx[1];
    end

    always_comb
    begin
        dec_next           = '0;
        dec_next.op        = in_op;
        dec_next.pal_index = in_pidx;
        dec_next.data      = (in_op == OP_PIXEL) ? in_word : in_pval;
        dec_next.tidx      = (in_op == OP_PIXEL) ? in_tbits : in_pidx[TPAL_AW-1:0];
        dec_next.tshow     = cfg.text_enable && (in_tbits != 4'd0);
        gshow_raw          = 1'b0;
        if (is16 && cfg.large_screen)
        begin
            dec_next.gidx = {4'd0, quad_idx};
            gshow_raw     = (quad_idx != 4'd0);
        end
        else if (cfg.page_enable_mask != 4'd0 && !outside)
        begin
            if (direct)
            begin
                dec_next.gdirect = 1'b1;
                gshow_raw        = (in_word != 16'd0);
            end
            else
            begin
                dec_next.gidx = found_idx;
                gshow_raw     = found;
            end
        end
        dec_next.gshow = cfg.graphic_enable && gshow_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            dec_reg <= dec_next;
    end

    a_direct_shown: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && dec_reg.op == OP_PIXEL && dec_reg.gdirect && dec_reg.gshow
        |-> dec_reg.data != 16'd0)
        else $error("direct colour shown with zero word");

endmodule

// ===== design/gtpc_palette.sv =====
// ---------------------------------------------------------------------------
// gtpc_palette
// Graphic and text palette memories: write on load requests, read on pixels.
// ---------------------------------------------------------------------------
module gtpc_palette
    import gtpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  dec_t        in_dec,
    output logic        out_valid,
    input  logic        out_ready,
    output pal_t        out_pal,
    output logic [15:0] gcolor,
    output logic [15:0] tcolor
);

    logic [15:0] gpal_mem [GPAL_DEPTH];
    logic [15:0] tpal_mem [TPAL_DEPTH];
    logic        valid_reg;
    pal_t        pal_reg;
    pal_t        pal_next;
    logic [15:0] grd_reg;
    logic [15:0] trd_reg;
    logic        advance;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_pal   = pal_reg;
    assign gcolor    = grd_reg;
    assign tcolor    = trd_reg;
    assign advance   = in_ready && in_valid;

    always_comb
    begin
        pal_next.op      = in_dec.op;
        pal_next.gshow   = in_dec.gshow;
        pal_next.gdirect = in_dec.gdirect;
        pal_next.data    = in_dec.data;
        pal_next.tshow   = in_dec.tshow;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pal_reg <= pal_next;
            grd_reg <= gpal_mem[in_dec.gidx];
            trd_reg <= tpal_mem[in_dec.tidx];
            if (in_dec.op == OP_WR_GPAL)
                gpal_mem[in_dec.pal_index] <= in_dec.data;
            if (in_dec.op == OP_WR_TPAL)
                tpal_mem[in_dec.tidx] <= in_dec.data;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(grd_reg) && $stable(trd_reg))
        else $error("palette read data lost while stalled");

endmodule

// ===== design/gtpc_compose.sv =====
// ---------------------------------------------------------------------------
// gtpc_compose
// Stack the graphic and text layers and convert GRBI to RGB565.
// ---------------------------------------------------------------------------
module gtpc_compose
    import gtpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  pal_t        in_pal,
    input  logic [15:0] gcolor,
    input  logic [15:0] tcolor,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_color
);

    logic        valid_reg;
    logic [15:0] color_reg;
    logic [15:0] color_next;
    op_t         op_reg;
    logic [15:0] gcol;
    logic        gbehind;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_color = color_reg;
    assign gbehind   = (cfg.glayer_prio >= cfg.tlayer_prio);
    assign gcol      = in_pal.gdirect ? in_pal.data : gcolor;

    always_comb
    begin
        color_next = 16'd0;
        if (in_pal.op == OP_PIXEL)
        begin
            if (in_pal.tshow && (gbehind || !in_pal.gshow))
                color_next = grbi_to_565(tcolor);
            else if (in_pal.gshow)
                color_next = grbi_to_565(gcol);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            color_reg <= color_next;
            op_reg    <= in_pal.op;
        end
    end

    a_load_black: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && op_reg != OP_PIXEL |-> color_reg == 16'd0)
        else $error("non-pixel request gave a colour");

endmodule

// ===== tb/graphic_text_pixel_compositor_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// graphic_text_pixel_compositor_tb
// Self-checking bench for the pixel compositor. It loads both palettes, runs
// directed requests on page ordering, large screen, the colour modes and the
// layer stacking, then random traffic over many register settings while both
// stream sides idle and stall at random. A shadow of the palettes and the
// registers works out the colour due for every accepted request, and each
// returned colour is compared with the oldest colour still due.
// ---------------------------------------------------------------------------
module graphic_text_pixel_compositor_tb;
    import gtpc_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int PIPE_DEPTH     = 3;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_REQUESTS = 67;

    localparam logic [1:0] MODE_DIRECT_RSVD = 2'd2;
    localparam logic [1:0] MODE_DIRECT      = 2'd3;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = OP_NONE;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_COLOR_MODE;
    logic [7:0]  cfg_data  = '0;

    cfg_t        active_cfg = '0;
    logic [15:0] graphic_palette_copy [GPAL_DEPTH];
    logic [15:0] text_palette_copy [TPAL_DEPTH];
    logic [15:0] expected_colors [$];
    logic [15:0] color_due;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;
    int error_count    = 0;
    int result_count   = 0;
    int pixel_count    = 0;
    int write_count    = 0;
    int unused_count   = 0;
    int setting_count  = 0;

    graphic_text_pixel_compositor u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("graphic_text_pixel_compositor verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_tready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            result_count++;
            if (expected_colors.size() == 0)
            begin
                $error("color: expected none, actual 0x%04h", m_tdata);
                error_count++;
            end
            else
            begin
                color_due = expected_colors.pop_front();
                if (m_tdata !== color_due)
                begin
                    $error("color: expected 0x%04h, actual 0x%04h", color_due, m_tdata);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [15:0] to_rgb565(input logic [15:0] grbi);
        logic [4:0] g;
        logic [4:0] r;
        logic [4:0] b;
        logic       i;
        g = grbi[15:11];
        r = grbi[10:6];
        b = grbi[5:1];
        i = grbi[0];
        return {r, g, i, b};
    endfunction

    function automatic logic [15:0] compose_pixel(input logic [9:0] x, input logic [9:0] y,
                                                  input logic [15:0] word,
                                                  input logic [3:0] tbits);
        logic        gshow;
        logic        tshow;
        logic        direct_mode;
        logic        outside;
        logic [15:0] gcol;
        logic [15:0] tcol;
        logic [1:0]  quad;
        logic [7:0]  idx;
        gshow       = 1'b0;
        gcol        = '0;
        direct_mode = (active_cfg.color_mode == MODE_DIRECT_RSVD) ||
                      (active_cfg.color_mode == MODE_DIRECT);
        outside     = (x >= PAGE_SIDE) || (y >= PAGE_SIDE);
        if (active_cfg.graphic_enable)
        begin
            if (active_cfg.color_mode == MODE_16 && active_cfg.large_screen)
            begin
                quad  = {y >= PAGE_SIDE, x >= PAGE_SIDE};
                idx   = {4'd0, word[quad * 4 +: 4]};
                gshow = (idx != 0);
                gcol  = to_rgb565(graphic_palette_copy[idx]);
            end
            else if (active_cfg.page_enable_mask != 0 && !outside)
            begin
                if (direct_mode)
                begin
                    gshow = (word != 0);
                    gcol  = to_rgb565(word);
                end
                else
                begin
                    // walk front to back; equal priority keeps the lower page in front
                    for (int pr = 0; pr < PAGE_CNT; pr++)
                    begin
                        for (int p = 0; p < PAGE_CNT; p++)
                        begin
                            if (!gshow && active_cfg.page_enable_mask[p] &&
                                active_cfg.page_priorities[p * 2 +: 2] == pr)
                            begin
                                if (active_cfg.color_mode == MODE_16)
                                    idx = {4'd0, word[p * 4 +: 4]};
                                else
                                    idx = word[(p % 2) * 8 +: 8];
                                if (idx != 0)
                                begin
                                    gshow = 1'b1;
                                    gcol  = to_rgb565(graphic_palette_copy[idx]);
                                end
                            end
                        end
                    end
                end
            end
        end
        tshow = active_cfg.text_enable && (tbits != 0);
        tcol  = to_rgb565(text_palette_copy[tbits]);
        if (active_cfg.glayer_prio >= active_cfg.tlayer_prio)
            return tshow ? tcol : (gshow ? gcol : 16'h0000);
        else
            return gshow ? gcol : (tshow ? tcol : 16'h0000);
    endfunction

    function automatic cfg_t make_cfg(input logic [1:0] mode, input logic ls,
                                      input logic [3:0] mask, input logic [7:0] prio,
                                      input logic gen, input logic ten,
                                      input logic [1:0] glp, input logic [1:0] tlp);
        cfg_t c;
        c.color_mode       = mode;
        c.large_screen     = ls;
        c.page_enable_mask = mask;
        c.page_priorities  = prio;
        c.graphic_enable   = gen;
        c.text_enable      = ten;
        c.glayer_prio      = glp;
        c.tlayer_prio      = tlp;
        return c;
    endfunction

    task automatic send_request(input op_t op, input logic [9:0] x, input logic [9:0] y,
                                input logic [15:0] word, input logic [3:0] tbits,
                                input logic [7:0] pidx, input logic [15:0] pval);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pval, pidx, tbits, word, y, x};
        do
            @(posedge clk);
        while (!s_tready);
        case (op)
            OP_PIXEL:
            begin
                expected_colors.push_back(compose_pixel(x, y, word, tbits));
                pixel_count++;
            end
            OP_WR_GPAL:
            begin
                graphic_palette_copy[pidx] = pval;
                expected_colors.push_back(16'h0000);
                write_count++;
            end
            OP_WR_TPAL:
            begin
                text_palette_copy[pidx[TPAL_AW-1:0]] = pval;
                expected_colors.push_back(16'h0000);
                write_count++;
            end
            default:
            begin
                expected_colors.push_back(16'h0000);
                unused_count++;
            end
        endcase
    endtask

    task automatic send_pixel(input logic [9:0] x, input logic [9:0] y,
                              input logic [15:0] word, input logic [3:0] tbits);
        send_request(OP_PIXEL, x, y, word, tbits, 8'($urandom_range(0, 255)),
                     16'($urandom_range(0, 65535)));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_colors.size() != 0);
    endtask

    task automatic apply_config(input cfg_t c);
        cfg_idx_t   idx;
        logic [7:0] value;
        drain_results();
        idx = idx.first();
        repeat (idx.num())
        begin
            case (idx)
                CFG_COLOR_MODE:   value = 8'(c.color_mode);
                CFG_LARGE_SCREEN: value = 8'(c.large_screen);
                CFG_PAGE_ENABLE:  value = 8'(c.page_enable_mask);
                CFG_PAGE_PRIO:    value = c.page_priorities;
                CFG_GRAPHIC_EN:   value = 8'(c.graphic_enable);
                CFG_TEXT_EN:      value = 8'(c.text_enable);
                CFG_GLAYER_PRIO:  value = 8'(c.glayer_prio);
                default:          value = 8'(c.tlayer_prio);
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            do
                @(posedge clk);
            while (!cfg_ready);
            idx = idx.next();
        end
        cfg_valid <= 1'b0;
        active_cfg = c;
        setting_count++;
    endtask

    task automatic test_palette_load();
        for (int i = 0; i < GPAL_DEPTH; i++)
            send_request(OP_WR_GPAL, 10'($urandom_range(0, 1023)),
                         10'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)),
                         4'($urandom_range(0, 15)), 8'(i), 16'($urandom_range(0, 65535)));
        // upper index bits carry junk and must be ignored
        for (int i = 0; i < TPAL_DEPTH; i++)
            send_request(OP_WR_TPAL, 10'($urandom_range(0, 1023)),
                         10'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)),
                         4'($urandom_range(0, 15)),
                         {4'($urandom_range(0, 15)), 4'(i)}, 16'($urandom_range(0, 65535)));
    endtask

    task automatic test_page_priority();
        apply_config(make_cfg(MODE_16, 1'b0, 4'hF, 8'h1B, 1'b1, 1'b0, 2'd0, 2'd0));
        send_pixel(10'd0, 10'd0, 16'h1234, 4'h0);
        send_pixel(10'd511, 10'd511, 16'h0234, 4'h0);
        send_pixel(10'd5, 10'd7, 16'h0004, 4'h0);
        send_pixel(10'd10, 10'd10, 16'h0000, 4'h0);
        send_pixel(10'd512, 10'd0, 16'hFFFF, 4'h0);
        send_pixel(10'd0, 10'd1023, 16'hFFFF, 4'h0);
        apply_config(make_cfg(MODE_16, 1'b0, 4'hF, 8'h00, 1'b1, 1'b0, 2'd0, 2'd0));
        send_pixel(10'd3, 10'd3, 16'hF0A0, 4'h0);
        send_pixel(10'd3, 10'd3, 16'hF0A1, 4'h0);
        apply_config(make_cfg(MODE_16, 1'b0, 4'h0, 8'h00, 1'b1, 1'b0, 2'd0, 2'd0));
        send_pixel(10'd1, 10'd1, 16'hFFFF, 4'h0);
    endtask

    task automatic test_large_screen();
        apply_config(make_cfg(MODE_16, 1'b1, 4'h0, 8'hFF, 1'b1, 1'b0, 2'd0, 2'd0));
        send_pixel(10'd0, 10'd0, 16'h4321, 4'h0);
        send_pixel(10'd1023, 10'd0, 16'h4321, 4'h0);
        send_pixel(10'd0, 10'd1023, 16'h4321, 4'h0);
        send_pixel(10'd1023, 10'd1023, 16'h4321, 4'h0);
        send_pixel(10'd600, 10'd600, 16'h0FFF, 4'h0);
    endtask

    task automatic test_color_modes();
        apply_config(make_cfg(MODE_256, 1'b0, 4'h3, 8'h04, 1'b1, 1'b0, 2'd0, 2'd0));
        send_pixel(10'd2, 10'd2, 16'hAB00, 4'h0);
        send_pixel(10'd2, 10'd2, 16'hABCD, 4'h0);
        apply_config(make_cfg(MODE_DIRECT, 1'b0, 4'h1, 8'h00, 1'b1, 1'b0, 2'd0, 2'd0));
        send_pixel(10'd4, 10'd4, 16'hFFFF, 4'h0);
        send_pixel(10'd4, 10'd4, 16'h0000, 4'h0);
        send_pixel(10'd700, 10'd3, 16'h1234, 4'h0);
        apply_config(make_cfg(MODE_DIRECT_RSVD, 1'b1, 4'h8, 8'h00, 1'b1, 1'b0, 2'd0, 2'd0));
        send_pixel(10'd6, 10'd6, 16'h8001, 4'h0);
        apply_config(make_cfg(MODE_DIRECT, 1'b0, 4'h0, 8'h00, 1'b1, 1'b0, 2'd0, 2'd0));
        send_pixel(10'd6, 10'd6, 16'hFFFF, 4'h0);
    endtask

    task automatic test_layer_stacking();
        apply_config(make_cfg(MODE_16, 1'b0, 4'h1, 8'h00, 1'b1, 1'b1, 2'd2, 2'd2));
        send_pixel(10'd0, 10'd0, 16'h0001, 4'hF);
        send_pixel(10'd0, 10'd0, 16'h0001, 4'h0);
        apply_config(make_cfg(MODE_16, 1'b0, 4'h1, 8'h00, 1'b1, 1'b1, 2'd0, 2'd3));
        send_pixel(10'd0, 10'd0, 16'h0001, 4'h1);
        send_pixel(10'd0, 10'd0, 16'h0000, 4'h8);
        send_request(OP_WR_TPAL, 10'd0, 10'd0, 16'h0000, 4'h0, 8'hF8, 16'h5A5A);
        send_pixel(10'd0, 10'd0, 16'h0000, 4'h8);
        send_request(OP_NONE, 10'd0, 10'd0, 16'h0001, 4'hF, 8'h01, 16'hFFFF);
    endtask

    task automatic test_random_traffic();
        cfg_t        c;
        int          roll;
        logic [9:0]  x;
        logic [9:0]  y;
        logic [15:0] word;
        logic [15:0] keep;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                c = make_cfg(MODE_DIRECT, 1'b1, 4'hF, 8'hFF, 1'b1, 1'b1, 2'd3, 2'd3);
            else if (phase == 1)
                c = make_cfg(MODE_16, 1'b0, 4'h0, 8'h00, 1'b0, 1'b0, 2'd0, 2'd0);
            else
                c = make_cfg(phase[1:0], 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                             8'($urandom_range(0, 255)), $urandom_range(0, 4) != 0,
                             $urandom_range(0, 4) != 0, 2'($urandom_range(0, 3)),
                             2'($urandom_range(0, 3)));
            apply_config(c);
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                // hold the sender until the pipeline is empty now and then
                if (n == PHASE_REQUESTS / 2 || $urandom_range(0, 49) == 0)
                    drain_results();
                x = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                                : 10'($urandom_range(0, 511));
                y = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                                : 10'($urandom_range(0, 511));
                word = 16'($urandom_range(0, 65535));
                keep = {{4{1'($urandom_range(0, 1))}}, {4{1'($urandom_range(0, 1))}},
                        {4{1'($urandom_range(0, 1))}}, {4{1'($urandom_range(0, 1))}}};
                case ($urandom_range(0, 3))
                    0:       word = word & keep;
                    1:       word = word & (16'h000F << (4 * $urandom_range(0, 3)));
                    2:       word = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                    default: ;
                endcase
                roll = $urandom_range(0, 99);
                if (roll < 84)
                    send_pixel(x, y, word, 4'($urandom_range(0, 15)));
                else if (roll < 92)
                    send_request(OP_WR_GPAL, x, y, word, 4'($urandom_range(0, 15)),
                                 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
                else if (roll < 97)
                    send_request(OP_WR_TPAL, x, y, word, 4'($urandom_range(0, 15)),
                                 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
                else
                    send_request(OP_NONE, x, y, word, 4'($urandom_range(0, 15)),
                                 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
            end
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_palette_load();
        test_page_priority();
        test_large_screen();
        test_color_modes();
        test_layer_stacking();
        test_random_traffic();
        drain_results();
        repeat (PIPE_DEPTH + 5) @(posedge clk);
        $display("Sent %0d requests: %0d pixels, %0d palette writes, %0d of unused op",
                 pixel_count + write_count + unused_count, pixel_count, write_count,
                 unused_count);
        $display("Went through %0d register settings and checked %0d colours",
                 setting_count, result_count);
        if (error_count == 0 && expected_colors.size() == 0)
            $display("graphic_text_pixel_compositor verification clean");
        else
            $display("graphic_text_pixel_compositor verification failed");
        $finish;
    end

endmodule
